>>> rtl/core/sle_pkg.sv
// ============================================================================
// sle_pkg
// Shared constants, types and controller/datapath interface structures for
// the serial line editor.
// ============================================================================
package sle_pkg;

   localparam int LINE_CAPACITY = 32;
   localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
   localparam int CNT_W         = $clog2(LINE_CAPACITY);
   localparam int IDX_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int STEP_W        = (CNT_W > 2) ? CNT_W : 2;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LOW   = 8'd32;
   localparam logic [7:0] CH_HIGH  = 8'd126;

   localparam logic DEST_ECHO = 1'b0;
   localparam logic DEST_LINE = 1'b1;

   // What an accepted byte asks of the block.
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_EOL   = 2'd1,
      KIND_BS    = 2'd2,
      KIND_PRINT = 2'd3
   } kind_type;

   // Which sequence the datapath is emitting from.
   typedef enum logic [1:0] {
      SRC_PRINT = 2'd0,
      SRC_EOL   = 2'd1,
      SRC_BS    = 2'd2,
      SRC_LINE  = 2'd3
   } src_type;

   typedef struct packed {
      logic    accept;
      logic    emit;
      src_type src;
      logic    step_clr;
      logic    count_clr;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     out_free;
      logic     seq_end;
      logic     line_empty;
   } sts_type;

endpackage

>>> rtl/core/sle_datapath.sv
// ============================================================================
// sle_datapath
// Line store, fill count, CR flag, sequence step counter and the result
// register for the serial line editor.
// ============================================================================
module sle_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_rx_byte,
   input  logic             rsp_stall,
   input  sle_pkg::cmd_type cmd,
   output sle_pkg::sts_type sts,
   output logic             rsp_valid,
   output logic             rsp_dest,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_end_of_line,
   output logic             rsp_last
);
   import sle_pkg::*;

   logic [7:0]        store_ff [STORE_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              prev_cr_ff, prev_cr_in;
   logic [7:0]        byte_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic              dest_ff, dest_in;
   logic [7:0]        data_ff, data_in;
   logic              eol_ff, eol_in;
   logic              last_ff, last_in;

   logic              is_cr, is_lf, is_bs, is_print;
   kind_type          kind;
   logic [STEP_W-1:0] step_nxt;
   logic              line_end;
   logic              seq_end;
   logic              store_wr;
   logic              store_rd;

   always_comb begin
      is_cr    = (req_rx_byte == CH_CR);
      is_lf    = (req_rx_byte == CH_LF);
      is_bs    = (req_rx_byte == CH_BS) || (req_rx_byte == CH_DEL);
      is_print = (req_rx_byte >= CH_LOW) && (req_rx_byte <= CH_HIGH);
      priority if (is_lf && prev_cr_ff) begin
         kind = KIND_NONE;
      end else if (is_cr || is_lf) begin
         kind = KIND_EOL;
      end else if (is_bs) begin
         kind = (count_ff != '0) ? KIND_BS : KIND_NONE;
      end else if (is_print) begin
         kind = (count_ff < CNT_W'(STORE_DEPTH)) ? KIND_PRINT : KIND_NONE;
      end else begin
         kind = KIND_NONE;
      end
   end

   assign step_nxt = step_ff + STEP_W'(1);
   assign line_end = (step_nxt == STEP_W'(count_ff));

   always_comb begin
      unique case (cmd.src)
         SRC_PRINT: seq_end = 1'b1;
         SRC_EOL:   seq_end = (step_ff == STEP_W'(1));
         SRC_BS:    seq_end = (step_ff == STEP_W'(2));
         SRC_LINE:  seq_end = line_end;
         default:   seq_end = 1'b1;
      endcase
   end

   assign sts.kind       = kind;
   assign sts.out_free   = !valid_ff || !rsp_stall;
   assign sts.seq_end    = seq_end;
   assign sts.line_empty = (count_ff == '0);

   assign store_wr = cmd.accept && (kind == KIND_PRINT);
   assign store_rd = cmd.emit && (cmd.src == SRC_LINE);

   always_comb begin
      count_in   = count_ff;
      prev_cr_in = prev_cr_ff;
      if (cmd.accept) begin
         // An LF never sets the flag, and a swallowed LF clears it.
         prev_cr_in = is_cr;
         if (kind == KIND_BS) begin
            count_in = count_ff - CNT_W'(1);
         end else if (kind == KIND_PRINT) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.count_clr) begin
         count_in = '0;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.step_clr) begin
         step_in = '0;
      end else if (cmd.emit) begin
         step_in = step_nxt;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      dest_in  = dest_ff;
      data_in  = data_ff;
      eol_in   = eol_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         dest_in  = DEST_ECHO;
         eol_in   = 1'b0;
         unique case (cmd.src)
            SRC_PRINT: begin
               data_in = byte_ff;
               last_in = 1'b1;
            end
            SRC_EOL: begin
               data_in = (step_ff == '0) ? CH_CR : CH_LF;
               last_in = seq_end && (count_ff == '0);
            end
            SRC_BS: begin
               data_in = (step_ff == STEP_W'(1)) ? CH_SPACE : CH_BS;
               last_in = seq_end;
            end
            SRC_LINE: begin
               // The line byte itself is read from the store in the clocked block.
               dest_in = DEST_LINE;
               eol_in  = line_end;
               last_in = line_end;
            end
            default: begin
               data_in = byte_ff;
               last_in = 1'b1;
            end
         endcase
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         prev_cr_ff <= 1'b0;
         step_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         prev_cr_ff <= prev_cr_in;
         step_ff    <= step_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_ff <= dest_in;
      eol_ff  <= eol_in;
      last_ff <= last_in;
      if (store_rd) begin
         data_ff <= store_ff[step_ff[IDX_W-1:0]];
      end else begin
         data_ff <= data_in;
      end
      if (cmd.accept) begin
         byte_ff <= req_rx_byte;
      end
      if (store_wr) begin
         store_ff[count_ff[IDX_W-1:0]] <= req_rx_byte;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_dest        = dest_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_end_of_line = eol_ff;
   assign rsp_last        = last_ff;

endmodule

>>> rtl/core/sle_ctrl.sv
// ============================================================================
// sle_ctrl
// Sequencing state machine for the serial line editor: accepts one byte and
// steps the datapath through the echo and line sequences it causes.
// ============================================================================
module sle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sle_pkg::sts_type sts,
   output sle_pkg::cmd_type cmd
);
   import sle_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PRINT = 5'b00010,
      ST_BS    = 5'b00100,
      ST_EOL   = 5'b01000,
      ST_LINE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.emit      = 1'b0;
      cmd.src       = SRC_PRINT;
      cmd.step_clr  = 1'b0;
      cmd.count_clr = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.step_clr = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (sts.kind)
                  KIND_PRINT: state_in = ST_PRINT;
                  KIND_BS:    state_in = ST_BS;
                  KIND_EOL:   state_in = ST_EOL;
                  KIND_NONE:  state_in = ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_PRINT: begin
            cmd.src = SRC_PRINT;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_BS: begin
            cmd.src = SRC_BS;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.seq_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EOL: begin
            cmd.src = SRC_EOL;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.seq_end) begin
                  // The line walk restarts the step counter at the first entry.
                  cmd.step_clr = 1'b1;
                  state_in     = sts.line_empty ? ST_IDLE : ST_LINE;
               end
            end
         end
         ST_LINE: begin
            cmd.src = SRC_LINE;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.seq_end) begin
                  cmd.count_clr = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/serial_line_editor.sv
// ============================================================================
// serial_line_editor
// Terminal line discipline with echo: edits a received line, echoes it and
// hands completed lines to the command side.
// ============================================================================
//
//   Channel  Dir  Handshake             Transaction
//   req      in   req_valid, req_stall  one received byte (req_rx_byte)
//   rsp      out  rsp_valid, rsp_stall  one echo or line byte (dest, data, eol, last)
//
// A byte that causes no result is only accepted; a printable byte is echoed, a
// backspace is echoed as BS, space, BS and an end of line as CR, LF followed by
// the buffered line bytes. While rsp does not stall, one result per cycle is loaded
// into a single output register and the line store is walked one entry per cycle.
// Synchronous reset clears fill count, CR flag, step, rsp_valid and sequencer only.
// A stall on rsp holds the sequence; req stalls until the byte's last result is loaded.
//
module serial_line_editor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_dest,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_end_of_line,
   output logic       rsp_last
);
   import sle_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sle_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_dest        (rsp_dest),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_end_of_line (rsp_end_of_line),
      .rsp_last        (rsp_last)
   );

endmodule
